### sv/tcse_pkg.sv
// Package with the shared types and constants of the terminal screen engine.
`timescale 1ns / 1ps
package tcse_pkg;

    localparam int COLUMNS   = 80;
    localparam int ROW_COUNT = 24;
    localparam int CELLS     = COLUMNS * ROW_COUNT;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int ROW_W     = 5;
    localparam int COL_W     = 7;

    localparam logic [7:0] CH_ESC   = 8'h1b;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_QUES  = 8'h3f;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] FIN_LO   = 8'h40;
    localparam logic [7:0] FIN_HI   = 8'h7e;
    localparam logic [7:0] FIN_A    = 8'h41;
    localparam logic [7:0] FIN_B    = 8'h42;
    localparam logic [7:0] FIN_C    = 8'h43;
    localparam logic [7:0] FIN_D    = 8'h44;
    localparam logic [7:0] FIN_H    = 8'h48;
    localparam logic [7:0] FIN_F    = 8'h66;
    localparam logic [7:0] FIN_J    = 8'h4a;
    localparam logic [7:0] FIN_K    = 8'h4b;
    localparam logic [15:0] PARAM_MAX = 16'hffff;

    localparam logic [1:0] PHASE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_ESC  = 2'd1;
    localparam logic [1:0] PHASE_CSI  = 2'd2;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_beat_t;

    typedef struct packed {
        logic [6:0] cell_char;
        logic [4:0] cursor_row;
        logic [6:0] cursor_col;
        logic [1:0] parser_phase;
    } out_beat_t;

    typedef enum logic [3:0] {
        ST_CLEAR,      // post-reset blanking pass
        ST_IDLE,
        ST_DECODE,     // decode registered item
        ST_READ,       // wait for memory read data
        ST_READ_DONE,
        ST_TAB,        // write one space per cycle
        ST_BLANK,      // blank a range of cells
        ST_SCROLL_RD,  // scroll: read cell below
        ST_SCROLL_WR,  // scroll: write it one row up
        ST_DONE
    } state_t;

    // Command word from the controller to the datapath.
    typedef struct packed {
        logic latch_item;
        logic decode;      // apply the byte's cursor/parser effect
        logic mem_rd;      // read at read address
        logic cap_read;    // capture read data as result
        logic tab_step;    // write a space at cursor and advance
        logic blank_init;  // load blanking range from decoded request
        logic clear_init;  // blank the bottom row after a scroll
        logic blank_step;
        logic scroll_init;
        logic scroll_rd;
        logic scroll_wr;
        logic emit;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic need_tab;
        logic need_blank;
        logic need_scroll;
        logic tab_last;
        logic blank_last;
        logic scroll_last;
    } stat_t;

endpackage

### sv/tcse_ctrl.sv
// Controller state machine of the terminal screen engine.
`timescale 1ns / 1ps
module tcse_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  tcse_pkg::stat_t stat,
    output tcse_pkg::ctrl_t ctrl,
    output logic            busy
);
    tcse_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcse_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl = '0;
        busy = 1'b1;
        unique case (state_reg)
            tcse_pkg::ST_CLEAR:
            begin
                ctrl.blank_step = 1'b1;
                if (stat.blank_last)
                begin
                    state_next = tcse_pkg::ST_IDLE;
                end
            end
            tcse_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.latch_item = 1'b1;
                    state_next = tcse_pkg::ST_DECODE;
                end
            end
            tcse_pkg::ST_DECODE:
            begin
                if (stat.is_read)
                begin
                    ctrl.mem_rd = 1'b1;
                    state_next = tcse_pkg::ST_READ;
                end
                else
                begin
                    ctrl.decode = 1'b1;
                    if (stat.need_tab)
                    begin
                        state_next = tcse_pkg::ST_TAB;
                    end
                    else if (stat.need_blank)
                    begin
                        ctrl.blank_init = 1'b1;
                        state_next = tcse_pkg::ST_BLANK;
                    end
                    else if (stat.need_scroll)
                    begin
                        ctrl.scroll_init = 1'b1;
                        state_next = tcse_pkg::ST_SCROLL_RD;
                    end
                    else
                    begin
                        state_next = tcse_pkg::ST_DONE;
                    end
                end
            end
            tcse_pkg::ST_READ:
            begin
                state_next = tcse_pkg::ST_READ_DONE;
            end
            tcse_pkg::ST_READ_DONE:
            begin
                ctrl.cap_read = 1'b1;
                state_next = tcse_pkg::ST_DONE;
            end
            tcse_pkg::ST_TAB:
            begin
                ctrl.tab_step = 1'b1;
                if (stat.need_scroll)
                begin
                    ctrl.scroll_init = 1'b1;
                    state_next = tcse_pkg::ST_SCROLL_RD;
                end
                else if (stat.tab_last)
                begin
                    state_next = tcse_pkg::ST_DONE;
                end
            end
            tcse_pkg::ST_BLANK:
            begin
                ctrl.blank_step = 1'b1;
                if (stat.blank_last)
                begin
                    state_next = tcse_pkg::ST_DONE;
                end
            end
            tcse_pkg::ST_SCROLL_RD:
            begin
                ctrl.scroll_rd = 1'b1;
                state_next = tcse_pkg::ST_SCROLL_WR;
            end
            tcse_pkg::ST_SCROLL_WR:
            begin
                ctrl.scroll_wr = 1'b1;
                if (stat.scroll_last)
                begin
                    ctrl.clear_init = 1'b1;
                    state_next = tcse_pkg::ST_BLANK;
                end
                else
                begin
                    state_next = tcse_pkg::ST_SCROLL_RD;
                end
            end
            tcse_pkg::ST_DONE:
            begin
                ctrl.emit = 1'b1;
                state_next = tcse_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tcse_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

### sv/tcse_datapath.sv
// Datapath of the terminal screen engine: screen memory, cursor and parser.
`timescale 1ns / 1ps
module tcse_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  tcse_pkg::in_beat_t  in_beat,
    input  tcse_pkg::ctrl_t     ctrl,
    output tcse_pkg::stat_t     stat,
    output tcse_pkg::out_beat_t out_beat,
    output logic                done
);
    localparam int AW = tcse_pkg::ADDR_W;
    localparam logic [AW-1:0] LAST_ROW_BASE = AW'(tcse_pkg::COLUMNS * (tcse_pkg::ROW_COUNT - 1));
    localparam logic [AW-1:0] CELLS_A       = AW'(tcse_pkg::CELLS);
    localparam logic [AW-1:0] COLS_A        = AW'(tcse_pkg::COLUMNS);
    localparam logic [6:0]    LAST_COL      = 7'(tcse_pkg::COLUMNS - 1);
    localparam logic [4:0]    LAST_ROW      = 5'(tcse_pkg::ROW_COUNT - 1);

    logic [6:0] mem [tcse_pkg::CELLS];
    logic [6:0] rd_data_reg;

    tcse_pkg::in_beat_t item_reg;
    logic [4:0]  row_reg, row_next;
    logic [6:0]  col_reg, col_next;
    logic [1:0]  phase_reg, phase_next;
    logic [15:0] p1_reg, p1_next, p2_reg, p2_next;
    logic [3:0]  pcnt_reg, pcnt_next;
    logic        seen_reg, seen_next;
    logic [AW-1:0] ptr_reg, ptr_next, end_reg, end_next;
    logic [6:0]  cell_reg;
    logic        done_reg;

    logic [7:0]  b;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] blank_from;
    logic        blank_req;
    logic        scroll_req;
    logic        tab_req;
    logic        in_range;
    logic [AW-1:0] rd_addr;
    logic        wr_en;
    logic [AW-1:0] wr_addr;
    logic [6:0]  wr_data;
    logic [15:0] n, m, cnt;
    logic [19:0] digit_val;
    logic [15:0] digit_sat;
    logic [16:0] sum17;

    assign b = item_reg.data_byte;
    // row*COLUMNS+col; narrow multiply by a constant.
    assign cur_addr = AW'(row_reg * tcse_pkg::COLUMNS) + AW'(col_reg);
    assign in_range = (item_reg.read_row < 5'(tcse_pkg::ROW_COUNT)) &&
                      (item_reg.read_col < 7'(tcse_pkg::COLUMNS));

    assign n   = seen_reg ? p1_reg : 16'd0;
    assign m   = (pcnt_reg >= 4'd1) ? p2_reg : 16'd0;
    assign cnt = (n == 16'd0) ? 16'd1 : n;
    assign digit_val = (((pcnt_reg == 4'd0) ? p1_reg : p2_reg) * 20'd10)
                       + 20'(b - tcse_pkg::CH_ZERO);
    assign digit_sat = (digit_val > 20'(tcse_pkg::PARAM_MAX)) ? tcse_pkg::PARAM_MAX
                                                              : digit_val[15:0];

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        phase_next = phase_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        pcnt_next = pcnt_reg;
        seen_next = seen_reg;
        blank_req = 1'b0;
        blank_from = cur_addr;
        scroll_req = 1'b0;
        tab_req = 1'b0;
        wr_en = 1'b0;
        wr_addr = cur_addr;
        wr_data = 7'(tcse_pkg::CH_SPACE);
        sum17 = '0;
        if (ctrl.decode)
        begin
            priority if (phase_reg == tcse_pkg::PHASE_IDLE)
            begin
                priority if (b == tcse_pkg::CH_ESC)
                begin
                    phase_next = tcse_pkg::PHASE_ESC;
                end
                else if (b == tcse_pkg::CH_CR)
                begin
                    col_next = '0;
                end
                else if (b == tcse_pkg::CH_LF)
                begin
                    col_next = '0;
                    if (row_reg == LAST_ROW)
                    begin
                        scroll_req = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 5'd1;
                    end
                end
                else if (b == tcse_pkg::CH_BS)
                begin
                    if (col_reg != 7'd0)
                    begin
                        col_next = col_reg - 7'd1;
                    end
                end
                else if (b == tcse_pkg::CH_TAB)
                begin
                    tab_req = 1'b1;
                end
                else if (b >= tcse_pkg::CH_SPACE && b < tcse_pkg::CH_DEL)
                begin
                    wr_en = 1'b1;
                    wr_data = b[6:0];
                    if (col_reg == LAST_COL)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_ROW)
                        begin
                            scroll_req = 1'b1;
                        end
                        else
                        begin
                            row_next = row_reg + 5'd1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 7'd1;
                    end
                end
                else
                begin
                    // Other control bytes, DEL and high bytes are dropped.
                end
            end
            else if (phase_reg == tcse_pkg::PHASE_ESC)
            begin
                if (b == tcse_pkg::CH_LBRK)
                begin
                    phase_next = tcse_pkg::PHASE_CSI;
                    p1_next = '0;
                    p2_next = '0;
                    pcnt_next = '0;
                    seen_next = 1'b0;
                end
                else
                begin
                    phase_next = tcse_pkg::PHASE_IDLE;
                end
            end
            else
            begin
                priority if (b >= tcse_pkg::CH_ZERO && b <= tcse_pkg::CH_NINE)
                begin
                    if (pcnt_reg == 4'd0)
                    begin
                        p1_next = digit_sat;
                    end
                    else if (pcnt_reg == 4'd1)
                    begin
                        p2_next = digit_sat;
                    end
                    seen_next = 1'b1;
                end
                else if (b == tcse_pkg::CH_SEMI)
                begin
                    if (pcnt_reg != 4'd15)
                    begin
                        pcnt_next = pcnt_reg + 4'd1;
                    end
                end
                else if (b == tcse_pkg::CH_QUES || b == tcse_pkg::CH_GT)
                begin
                    phase_next = phase_reg;
                end
                else if (b >= tcse_pkg::FIN_LO && b <= tcse_pkg::FIN_HI)
                begin
                    phase_next = tcse_pkg::PHASE_IDLE;
                    priority if (b == tcse_pkg::FIN_A)
                    begin
                        row_next = (cnt >= 16'(row_reg)) ? 5'd0 : row_reg - cnt[4:0];
                    end
                    else if (b == tcse_pkg::FIN_B)
                    begin
                        sum17 = 17'(row_reg) + 17'(cnt);
                        row_next = (sum17 >= 17'(tcse_pkg::ROW_COUNT)) ? LAST_ROW
                                                                        : sum17[4:0];
                    end
                    else if (b == tcse_pkg::FIN_C)
                    begin
                        sum17 = 17'(col_reg) + 17'(cnt);
                        col_next = (sum17 >= 17'(tcse_pkg::COLUMNS)) ? LAST_COL
                                                                      : sum17[6:0];
                    end
                    else if (b == tcse_pkg::FIN_D)
                    begin
                        col_next = (cnt >= 16'(col_reg)) ? 7'd0 : col_reg - cnt[6:0];
                    end
                    else if (b == tcse_pkg::FIN_H || b == tcse_pkg::FIN_F)
                    begin
                        row_next = (n > 16'(tcse_pkg::ROW_COUNT)) ? LAST_ROW
                                 : ((n == 16'd0) ? 5'd0 : 5'(n - 16'd1));
                        col_next = (m > 16'(tcse_pkg::COLUMNS)) ? LAST_COL
                                 : ((m == 16'd0) ? 7'd0 : 7'(m - 16'd1));
                    end
                    else if (b == tcse_pkg::FIN_J)
                    begin
                        if (n == 16'd0)
                        begin
                            blank_req = 1'b1;
                        end
                        else if (n == 16'd2)
                        begin
                            blank_req = 1'b1;
                            blank_from = '0;
                            row_next = '0;
                            col_next = '0;
                        end
                    end
                    else if (b == tcse_pkg::FIN_K)
                    begin
                        blank_req = 1'b1;
                    end
                    else
                    begin
                        // Other finals only end the sequence.
                    end
                end
                else
                begin
                    phase_next = tcse_pkg::PHASE_IDLE;
                end
            end
        end
        else if (ctrl.tab_step)
        begin
            wr_en = 1'b1;
            if (col_reg == LAST_COL)
            begin
                col_next = '0;
                if (row_reg == LAST_ROW)
                begin
                    scroll_req = 1'b1;
                end
                else
                begin
                    row_next = row_reg + 5'd1;
                end
            end
            else
            begin
                col_next = col_reg + 7'd1;
            end
        end
        else if (ctrl.blank_step)
        begin
            wr_en = 1'b1;
            wr_addr = ptr_reg;
        end
        else if (ctrl.scroll_wr)
        begin
            wr_en = 1'b1;
            wr_addr = ptr_reg;
            wr_data = rd_data_reg;
        end
    end

    // Blanking end for the current request: end of line for EL, else end of screen.
    logic [AW-1:0] line_end;
    assign line_end = AW'(row_reg * tcse_pkg::COLUMNS) + COLS_A;

    always_comb
    begin
        ptr_next = ptr_reg;
        end_next = end_reg;
        if (ctrl.blank_init)
        begin
            ptr_next = blank_from;
            end_next = (b == tcse_pkg::FIN_K) ? line_end : CELLS_A;
        end
        else if (ctrl.scroll_init)
        begin
            ptr_next = '0;
        end
        else if (ctrl.clear_init)
        begin
            ptr_next = LAST_ROW_BASE;
            end_next = CELLS_A;
        end
        else if (ctrl.blank_step || ctrl.scroll_wr)
        begin
            ptr_next = ptr_reg + AW'(1);
        end
    end

    assign rd_addr = ctrl.scroll_rd ? (ptr_reg + COLS_A)
                   : (AW'(item_reg.read_row * tcse_pkg::COLUMNS) + AW'(item_reg.read_col));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.mem_rd || ctrl.scroll_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (ctrl.latch_item)
        begin
            item_reg <= in_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            phase_reg <= tcse_pkg::PHASE_IDLE;
            p1_reg <= '0;
            p2_reg <= '0;
            pcnt_reg <= '0;
            seen_reg <= 1'b0;
            ptr_reg <= '0;
            end_reg <= CELLS_A;
            cell_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            phase_reg <= phase_next;
            p1_reg <= p1_next;
            p2_reg <= p2_next;
            pcnt_reg <= pcnt_next;
            seen_reg <= seen_next;
            ptr_reg <= ptr_next;
            end_reg <= end_next;
            done_reg <= ctrl.emit;
            if (ctrl.latch_item)
            begin
                cell_reg <= '0;
            end
            else if (ctrl.cap_read)
            begin
                cell_reg <= in_range ? rd_data_reg : 7'd0;
            end
        end
    end

    assign stat.is_read     = item_reg.mode;
    assign stat.need_tab    = tab_req;
    assign stat.need_blank  = blank_req;
    assign stat.need_scroll = scroll_req;
    assign stat.tab_last    = (col_next[2:0] == 3'd0);
    assign stat.blank_last  = (ptr_reg + AW'(1) >= end_reg);
    assign stat.scroll_last = (ptr_reg + AW'(1) == LAST_ROW_BASE);

    assign out_beat.cell_char    = cell_reg;
    assign out_beat.cursor_row   = row_reg;
    assign out_beat.cursor_col   = col_reg;
    assign out_beat.parser_phase = phase_reg;
    assign done = done_reg;
endmodule

### sv/text_terminal_csi_screen_engine_core.sv
// Top level of the terminal screen engine: controller plus datapath.
`timescale 1ns / 1ps
//  channel   signals              beat taken when
//  command   start, busy, cmd     start high and busy low at a rising edge
//  result    done, result         done high for one cycle; cannot be held off
//
// A cell read passes decode, read, read-done and done; a byte or cursor move
// passes decode and done; a tab writes one space at a time. The memory port
// sets the long cases: a scroll reads and rewrites each moved cell, then
// blanks the bottom row; a full erase blanks every cell. After reset the
// block blanks all 1920 cells, one a cycle, with busy high. The receiver
// cannot stall, so the result beat is always shown for exactly one cycle.
module text_terminal_csi_screen_engine_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  tcse_pkg::in_beat_t  cmd,
    output logic                busy,
    output logic                done,
    output tcse_pkg::out_beat_t result
);
    tcse_pkg::ctrl_t ctrl;
    tcse_pkg::stat_t stat;

    tcse_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .ctrl (ctrl),
        .busy (busy)
    );

    tcse_datapath u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_beat (cmd),
        .ctrl    (ctrl),
        .stat    (stat),
        .out_beat(result),
        .done    (done)
    );

    // The result strobe is raised in the cycle after the controller's emit.
    a_done_follows_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.emit |=> done) else $error("result strobe missing");
    // A result beat is shown only once the controller is back in idle.
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result shown while busy");
    // The cursor stays on the screen.
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.cursor_row < 5'(tcse_pkg::ROW_COUNT)) &&
                 (result.cursor_col < 7'(tcse_pkg::COLUMNS)))
        else $error("cursor off screen");
endmodule

### tb/text_terminal_csi_screen_engine_core_test.sv
// Self-checking testbench for the terminal screen engine core.
`timescale 1ns / 1ps
// The test feeds host bytes and cell reads to the core through its command
// channel and checks every result beat against an internal model of the
// screen, the cursor and the escape-sequence parser. Each beat is predicted
// when the driver sees it accepted, and the monitor compares the result beats
// in order. The run has three phases of idling: sender idle rarely, sender
// idle often, and no idling at all.
module text_terminal_csi_screen_engine_core_test;

    logic                clk;
    logic                rst_n;
    logic                start;
    tcse_pkg::in_beat_t  cmd;
    logic                busy;
    logic                done;
    tcse_pkg::out_beat_t result;

    text_terminal_csi_screen_engine_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Model state of the terminal.
    logic [6:0]  screen_model [tcse_pkg::CELLS];
    int          row_m;
    int          col_m;
    logic [1:0]  phase_m;
    int          par0_m;
    int          par1_m;
    int          sep_count_m;
    bit          digit_m;

    tcse_pkg::in_beat_t  pending_beats [$];
    tcse_pkg::out_beat_t expected_results [$];
    int          error_count;
    int          idle_percent;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic void blank_range(input int from, input int upto);
        for (int i = from; i < upto && i < tcse_pkg::CELLS; i++)
            screen_model[i] = tcse_pkg::CH_SPACE[6:0];
    endfunction

    function automatic void line_advance();
        col_m = 0;
        row_m++;
        if (row_m >= tcse_pkg::ROW_COUNT)
        begin
            for (int i = 0; i < tcse_pkg::COLUMNS * (tcse_pkg::ROW_COUNT - 1); i++)
                screen_model[i] = screen_model[i + tcse_pkg::COLUMNS];
            blank_range(tcse_pkg::COLUMNS * (tcse_pkg::ROW_COUNT - 1), tcse_pkg::CELLS);
            row_m = tcse_pkg::ROW_COUNT - 1;
        end
    endfunction

    function automatic void write_cell(input logic [7:0] ch);
        screen_model[row_m * tcse_pkg::COLUMNS + col_m] = ch[6:0];
        col_m++;
        if (col_m >= tcse_pkg::COLUMNS)
            line_advance();
    endfunction

    function automatic int digit_add(input int p, input int d);
        int v;
        v = p * 10 + d;
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic void apply_final(input logic [7:0] fin);
        int n;
        int m;
        int cnt;
        n = digit_m ? par0_m : 0;
        m = (sep_count_m >= 1) ? par1_m : 0;
        cnt = (n < 1) ? 1 : n;
        case (fin)
            tcse_pkg::FIN_A: row_m = (cnt >= row_m) ? 0 : row_m - cnt;
            tcse_pkg::FIN_B:
                row_m = (row_m + cnt >= tcse_pkg::ROW_COUNT) ? tcse_pkg::ROW_COUNT - 1
                                                             : row_m + cnt;
            tcse_pkg::FIN_C:
                col_m = (col_m + cnt >= tcse_pkg::COLUMNS) ? tcse_pkg::COLUMNS - 1
                                                           : col_m + cnt;
            tcse_pkg::FIN_D: col_m = (cnt >= col_m) ? 0 : col_m - cnt;
            tcse_pkg::FIN_H, tcse_pkg::FIN_F:
            begin
                row_m = (n > 0) ? n - 1 : 0;
                col_m = (m > 0) ? m - 1 : 0;
                if (row_m >= tcse_pkg::ROW_COUNT) row_m = tcse_pkg::ROW_COUNT - 1;
                if (col_m >= tcse_pkg::COLUMNS) col_m = tcse_pkg::COLUMNS - 1;
            end
            tcse_pkg::FIN_J:
            begin
                if (n == 0)
                    blank_range(row_m * tcse_pkg::COLUMNS + col_m, tcse_pkg::CELLS);
                else if (n == 2)
                begin
                    blank_range(0, tcse_pkg::CELLS);
                    row_m = 0;
                    col_m = 0;
                end
            end
            tcse_pkg::FIN_K:
                blank_range(row_m * tcse_pkg::COLUMNS + col_m,
                            row_m * tcse_pkg::COLUMNS + tcse_pkg::COLUMNS);
            default: ;
        endcase
    endfunction

    // Applies one host byte to the model terminal.
    function automatic void feed_terminal(input logic [7:0] b);
        if (phase_m == tcse_pkg::PHASE_IDLE)
        begin
            if (b == tcse_pkg::CH_ESC)
                phase_m = tcse_pkg::PHASE_ESC;
            else if (b == tcse_pkg::CH_CR)
                col_m = 0;
            else if (b == tcse_pkg::CH_LF)
                line_advance();
            else if (b == tcse_pkg::CH_BS)
            begin
                if (col_m > 0) col_m--;
            end
            else if (b == tcse_pkg::CH_TAB)
            begin
                do
                    write_cell(tcse_pkg::CH_SPACE);
                while (col_m % 8 != 0);
            end
            else if (b >= tcse_pkg::CH_SPACE && b < tcse_pkg::CH_DEL)
                write_cell(b);
        end
        else if (phase_m == tcse_pkg::PHASE_ESC)
        begin
            if (b == tcse_pkg::CH_LBRK)
            begin
                phase_m = tcse_pkg::PHASE_CSI;
                par0_m = 0;
                par1_m = 0;
                sep_count_m = 0;
                digit_m = 1'b0;
            end
            else
                phase_m = tcse_pkg::PHASE_IDLE;
        end
        else
        begin
            if (b >= tcse_pkg::CH_ZERO && b <= tcse_pkg::CH_NINE)
            begin
                if (sep_count_m == 0)
                    par0_m = digit_add(par0_m, b - tcse_pkg::CH_ZERO);
                else if (sep_count_m == 1)
                    par1_m = digit_add(par1_m, b - tcse_pkg::CH_ZERO);
                digit_m = 1'b1;
            end
            else if (b == tcse_pkg::CH_SEMI)
            begin
                if (sep_count_m < 15) sep_count_m++;
            end
            else if (b == tcse_pkg::CH_QUES || b == tcse_pkg::CH_GT)
            begin
            end
            else if (b >= tcse_pkg::FIN_LO && b <= tcse_pkg::FIN_HI)
            begin
                apply_final(b);
                phase_m = tcse_pkg::PHASE_IDLE;
            end
            else
                phase_m = tcse_pkg::PHASE_IDLE;
        end
    endfunction

    function automatic tcse_pkg::out_beat_t predict_beat(input tcse_pkg::in_beat_t it);
        tcse_pkg::out_beat_t r;
        r.cell_char = 7'd0;
        if (!it.mode)
            feed_terminal(it.data_byte);
        else if (it.read_row < tcse_pkg::ROW_COUNT && it.read_col < tcse_pkg::COLUMNS)
            r.cell_char = screen_model[it.read_row * tcse_pkg::COLUMNS + it.read_col];
        r.cursor_row = row_m[4:0];
        r.cursor_col = col_m[6:0];
        r.parser_phase = phase_m;
        return r;
    endfunction

    // Driver: presents the head of the queue at the falling edge and pops it
    // once a rising edge has taken it (start high, busy low).
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            expected_results.push_back(predict_beat(cmd));
            void'(pending_beats.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= idle_percent)
        begin
            start <= 1'b1;
            cmd   <= pending_beats[0];
        end
        else
        begin
            start <= 1'b0;
            cmd   <= tcse_pkg::in_beat_t'($urandom);
        end
    end

    // Monitor: the result beat is valid for exactly one cycle.
    always @(posedge clk)
    begin
        tcse_pkg::out_beat_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.cell_char !== want.cell_char)
                    report_mismatch("cell_char", result.cell_char, want.cell_char);
                if (result.cursor_row !== want.cursor_row)
                    report_mismatch("cursor_row", result.cursor_row, want.cursor_row);
                if (result.cursor_col !== want.cursor_col)
                    report_mismatch("cursor_col", result.cursor_col, want.cursor_col);
                if (result.parser_phase !== want.parser_phase)
                    report_mismatch("parser_phase", result.parser_phase,
                                    want.parser_phase);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        tcse_pkg::in_beat_t it;
        it = tcse_pkg::in_beat_t'($urandom);
        it.mode = 1'b0;
        it.data_byte = b;
        pending_beats.push_back(it);
    endtask

    task automatic push_read(input logic [4:0] r, input logic [6:0] c);
        tcse_pkg::in_beat_t it;
        it = tcse_pkg::in_beat_t'($urandom);
        it.mode = 1'b1;
        it.read_row = r;
        it.read_col = c;
        pending_beats.push_back(it);
    endtask

    task automatic push_number(input int v);
        string s;
        s.itoa(v);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // One random item: mostly well-formed control sequences and text, with
    // some reads, noise and broken sequences.
    task automatic push_random_item();
        int kind;
        logic [7:0] finals [10];
        finals = '{tcse_pkg::FIN_A, tcse_pkg::FIN_B, tcse_pkg::FIN_C, tcse_pkg::FIN_D,
                   tcse_pkg::FIN_H, tcse_pkg::FIN_F, tcse_pkg::FIN_J, tcse_pkg::FIN_K,
                   8'h6d, 8'h40};
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            push_byte(tcse_pkg::CH_ESC);
            push_byte(tcse_pkg::CH_LBRK);
            if ($urandom_range(4) == 0) push_byte(tcse_pkg::CH_QUES);
            if ($urandom_range(2) != 0) push_number($urandom_range(30));
            if ($urandom_range(2) == 0)
            begin
                push_byte(tcse_pkg::CH_SEMI);
                if ($urandom_range(5) == 0) push_byte(tcse_pkg::CH_SEMI);
                if ($urandom_range(2) != 0) push_number($urandom_range(90));
            end
            if ($urandom_range(9) == 0) push_number($urandom_range(99999));
            if ($urandom_range(12) == 0)
                push_byte(8'(8'h20 + $urandom_range(15)));
            else
                push_byte(finals[$urandom_range(9)]);
        end
        else if (kind < 55)
            push_byte(8'(8'h20 + $urandom_range(94)));
        else if (kind < 70)
            push_read(5'($urandom_range(tcse_pkg::ROW_COUNT - 1)),
                      7'($urandom_range(tcse_pkg::COLUMNS - 1)));
        else if (kind < 73)
            push_read(5'($urandom), 7'($urandom));
        else if (kind < 85)
        begin
            case ($urandom_range(3))
                0: push_byte(tcse_pkg::CH_CR);
                1: push_byte(tcse_pkg::CH_LF);
                2: push_byte(tcse_pkg::CH_BS);
                default: push_byte(tcse_pkg::CH_TAB);
            endcase
        end
        else if (kind < 90)
        begin
            push_byte(tcse_pkg::CH_ESC);
            push_byte(8'($urandom));
        end
        else
            push_byte(8'($urandom));
    endtask

    task automatic wait_drained();
        while (pending_beats.size() > 0 || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        error_count = 0;
        idle_percent = 8;
        start = 1'b0;
        cmd = '0;
        for (int i = 0; i < tcse_pkg::CELLS; i++)
            screen_model[i] = tcse_pkg::CH_SPACE[6:0];
        row_m = 0;
        col_m = 0;
        phase_m = tcse_pkg::PHASE_IDLE;
        par0_m = 0;
        par1_m = 0;
        sep_count_m = 0;
        digit_m = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: extreme bytes, tab, a cursor move and a full erase,
        // saturating parameter, aborted and dropped sequences, reads out of
        // range.
        push_byte(8'h7e);
        push_byte(tcse_pkg::CH_TAB);
        push_byte(8'hff);
        push_byte(tcse_pkg::CH_DEL);
        push_byte(8'h07);
        push_read(5'd0, 7'd0);
        push_read(5'd31, 7'd127);
        push_read(5'd0, 7'd80);
        push_byte(tcse_pkg::CH_ESC);
        push_byte(8'h41);
        push_byte(tcse_pkg::CH_ESC);
        push_byte(tcse_pkg::CH_LBRK);
        push_byte(tcse_pkg::CH_GT);
        push_number(99999);
        push_byte(tcse_pkg::CH_SEMI);
        push_number(200);
        push_byte(tcse_pkg::FIN_H);
        push_byte(8'h41);
        push_byte(tcse_pkg::CH_LF);
        push_read(5'd23, 7'd79);
        push_byte(tcse_pkg::CH_ESC);
        push_byte(tcse_pkg::CH_LBRK);
        push_byte(8'h32);
        push_byte(tcse_pkg::FIN_J);
        push_read(5'd22, 7'd79);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            idle_percent = (ph == 0) ? 8 : (ph == 1) ? 54 : 0;
            while (pending_beats.size() < 72)
                push_random_item();
            wait_drained();
        end

        // Feed twelve lines of text so that scrolling is exercised if the cursor is in the lower half.
        idle_percent = 0;
        for (int i = 0; i < 12; i++)
        begin
            push_byte(8'(8'h61 + i));
            push_byte(tcse_pkg::CH_LF);
        end
        for (int i = 0; i < 16; i++)
            push_read(5'($urandom_range(tcse_pkg::ROW_COUNT - 1)),
                      7'($urandom_range(tcse_pkg::COLUMNS - 1)));
        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("text_terminal_csi_screen_engine_core test passed");
        else
            $display("text_terminal_csi_screen_engine_core test failed");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("text_terminal_csi_screen_engine_core test failed");
        $finish;
    end

endmodule
